/* hw/rtl/twsm_pkg.sv */
`default_nettype none

package twsm_pkg;

  // Transfer state of the bit engine.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2,
    MODE_GAP  = 2'd3
  } mode_t;

  // Command codes carried on in_tuser.
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SEND = 2'd1,
    OP_RECV = 2'd2,
    OP_END  = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CLOCK_IDLE_HIGH = 3'd0;
  localparam logic [2:0] CFG_SAMPLE_TRAILING = 3'd1;
  localparam logic [2:0] CFG_LSB_FIRST       = 3'd2;
  localparam logic [2:0] CFG_LAST_BITS       = 3'd3;
  localparam logic [2:0] CFG_BIT_DELAY       = 3'd4;
  localparam logic [2:0] CFG_BYTE_DELAY      = 3'd5;

  localparam int unsigned BYTE_BITS = 8;
  localparam logic [3:0] FULL_BYTE_BITS = 4'd8;
  localparam logic [7:0] RX_MASK_MSB = 8'h80;
  localparam logic [7:0] RX_MASK_LSB = 8'h01;

  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 24;

endpackage

`default_nettype wire

/* hw/rtl/three_wire_spi_master.sv */
`default_nettype none

// Half-duplex three-wire SPI master with a single shared data pin. Every input
// word is one tick of the bit timer and produces exactly one result word that
// shows the pin levels (sclk, dio_out, dio_drive, chip select) and status after
// that tick. All state updates for a word happen through a single layer of
// next-state logic into the state registers, with the result held in an output
// register; one word is taken per clock cycle as long as the result side keeps
// up, and a stalled result stalls the input by at most that one register. A
// send or receive command while idle selects a device and shifts one byte; each
// clock half lasts bit_delay+1 ticks, a byte ends with one completion tick
// (rx_valid for receives) and byte_delay gap ticks. Commands other than a plain
// tick while a byte or gap is in progress are dropped and flagged with
// cmd_rejected. The user must write configuration only while idle (not enforced).
module three_wire_spi_master #(
  parameter int unsigned DEVICE_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: tx_byte[7:0], device[10:8], dio_in[11], zero[15:12]
  input  wire logic [twsm_pkg::IN_DATA_W-1:0] in_tdata,
  // in_tuser: op[1:0]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: sclk[0], dio_out[1], dio_drive[2], cs_active[3], cs_device[6:4],
  //            busy_res[7], rx_byte[15:8], cmd_rejected[16], zero[23:17]
  output logic [twsm_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: rx_valid[0]
  output logic             out_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready
);
  import twsm_pkg::*;

  localparam logic [3:0] DEV_LIMIT = 4'(DEVICE_COUNT);
  localparam logic [2:0] DEV_MAX   = 3'(DEVICE_COUNT - 1);

  // Configuration registers.
  logic       clock_idle_high_r, sample_trailing_r, lsb_first_r;
  logic [3:0] last_bits_r;
  logic [7:0] bit_delay_r, byte_delay_r;

  // Engine state.
  mode_t      mode_r, mode_nxt;
  logic       select_on_r, select_on_nxt;
  logic [2:0] select_index_r, select_index_nxt;
  logic [7:0] shift_reg_r, shift_reg_nxt;
  logic [7:0] receive_acc_r, receive_acc_nxt;
  logic [3:0] bits_left_r, bits_left_nxt;
  logic       second_half_r, second_half_nxt;
  logic [7:0] tick_count_r, tick_count_nxt;
  logic       data_level_r, data_level_nxt;
  logic       drive_enable_r, drive_enable_nxt;

  // Result register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;

  op_t        op;
  logic [7:0] tx_byte;
  logic [2:0] device;
  logic       dio_in;
  logic       in_acc;

  logic [3:0] nb;
  logic [7:0] rx_out;
  logic       rx_flag;
  logic       rejected;
  logic       clock_level;

  assign op      = op_t'(in_tuser);
  assign tx_byte = in_tdata[7:0];
  assign device  = in_tdata[10:8];
  assign dio_in  = in_tdata[11];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_idle_high_r <= 1'b0;
      sample_trailing_r <= 1'b0;
      lsb_first_r       <= 1'b0;
      last_bits_r       <= FULL_BYTE_BITS;
      bit_delay_r       <= 8'd0;
      byte_delay_r      <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CLOCK_IDLE_HIGH: clock_idle_high_r <= cfg_data[0];
        CFG_SAMPLE_TRAILING: sample_trailing_r <= cfg_data[0];
        CFG_LSB_FIRST:       lsb_first_r       <= cfg_data[0];
        CFG_LAST_BITS:       last_bits_r       <= cfg_data[3:0];
        CFG_BIT_DELAY:       bit_delay_r       <= cfg_data;
        CFG_BYTE_DELAY:      byte_delay_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_nxt         = mode_r;
    select_on_nxt    = select_on_r;
    select_index_nxt = select_index_r;
    shift_reg_nxt    = shift_reg_r;
    receive_acc_nxt  = receive_acc_r;
    bits_left_nxt    = bits_left_r;
    second_half_nxt  = second_half_r;
    tick_count_nxt   = tick_count_r;
    data_level_nxt   = data_level_r;
    drive_enable_nxt = drive_enable_r;
    rx_out           = 8'd0;
    rx_flag          = 1'b0;
    rejected         = 1'b0;
    nb               = FULL_BYTE_BITS;

    if (mode_r == MODE_IDLE) begin
      if (op == OP_SEND || op == OP_RECV) begin
        if (in_tlast) begin
          nb = (last_bits_r > FULL_BYTE_BITS) ? FULL_BYTE_BITS : last_bits_r;
        end
        select_on_nxt    = 1'b1;
        select_index_nxt = ({1'b0, device} >= DEV_LIMIT) ? DEV_MAX : device;
        bits_left_nxt    = nb;
        receive_acc_nxt  = 8'd0;
        if (op == OP_SEND) begin
          mode_nxt         = MODE_SEND;
          drive_enable_nxt = 1'b1;
          shift_reg_nxt    = tx_byte;
        end else begin
          mode_nxt         = MODE_RECV;
          drive_enable_nxt = 1'b0;
          shift_reg_nxt    = lsb_first_r ? RX_MASK_LSB : RX_MASK_MSB;
        end
        if (nb == 4'd0) begin
          // Empty byte: this tick is already the completion tick.
          if (mode_nxt == MODE_RECV) begin
            rx_out  = receive_acc_nxt;
            rx_flag = 1'b1;
          end
          second_half_nxt = 1'b0;
          tick_count_nxt  = byte_delay_r;
          mode_nxt        = (byte_delay_r != 8'd0) ? MODE_GAP : MODE_IDLE;
        end else begin
          second_half_nxt = 1'b0;
          tick_count_nxt  = bit_delay_r;
          if (mode_nxt == MODE_SEND) begin
            data_level_nxt = lsb_first_r ? shift_reg_nxt[0] : shift_reg_nxt[BYTE_BITS-1];
          end else if (!sample_trailing_r && dio_in) begin
            receive_acc_nxt = receive_acc_nxt | shift_reg_nxt;
          end
        end
      end else if (op == OP_END) begin
        select_on_nxt    = 1'b0;
        drive_enable_nxt = 1'b1;
      end
    end else begin
      rejected = (op != OP_TICK);
      if (mode_r == MODE_GAP) begin
        if (tick_count_r != 8'd0) begin
          tick_count_nxt = tick_count_r - 8'd1;
        end
        if (tick_count_nxt == 8'd0) begin
          mode_nxt = MODE_IDLE;
        end
      end else if (tick_count_r != 8'd0) begin
        tick_count_nxt = tick_count_r - 8'd1;
      end else if (!second_half_r) begin
        second_half_nxt = 1'b1;
        tick_count_nxt  = bit_delay_r;
        if (mode_r == MODE_RECV && sample_trailing_r && dio_in) begin
          receive_acc_nxt = receive_acc_r | shift_reg_r;
        end
      end else begin
        if (bits_left_r != 4'd0) begin
          bits_left_nxt = bits_left_r - 4'd1;
        end
        // Send shifts data toward the output end; receive walks its bit mask.
        if ((mode_r == MODE_SEND) == lsb_first_r) begin
          shift_reg_nxt = {1'b0, shift_reg_r[7:1]};
        end else begin
          shift_reg_nxt = {shift_reg_r[6:0], 1'b0};
        end
        if (bits_left_nxt != 4'd0) begin
          second_half_nxt = 1'b0;
          tick_count_nxt  = bit_delay_r;
          if (mode_r == MODE_SEND) begin
            data_level_nxt = lsb_first_r ? shift_reg_nxt[0] : shift_reg_nxt[BYTE_BITS-1];
          end else if (!sample_trailing_r && dio_in) begin
            receive_acc_nxt = receive_acc_r | shift_reg_nxt;
          end
        end else begin
          if (mode_r == MODE_RECV) begin
            rx_out  = receive_acc_r;
            rx_flag = 1'b1;
          end
          second_half_nxt = 1'b0;
          tick_count_nxt  = byte_delay_r;
          mode_nxt        = (byte_delay_r != 8'd0) ? MODE_GAP : MODE_IDLE;
        end
      end
    end

    if ((mode_nxt == MODE_SEND || mode_nxt == MODE_RECV) && !second_half_nxt) begin
      clock_level = ~clock_idle_high_r;
    end else begin
      clock_level = clock_idle_high_r;
    end

    out_data_nxt = {7'd0, rejected, rx_out, (mode_nxt != MODE_IDLE), select_index_nxt,
                    select_on_nxt, drive_enable_nxt, data_level_nxt, clock_level};
    out_user_nxt = rx_flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_IDLE;
      select_on_r    <= 1'b0;
      select_index_r <= 3'd0;
      shift_reg_r    <= 8'd0;
      receive_acc_r  <= 8'd0;
      bits_left_r    <= 4'd0;
      second_half_r  <= 1'b0;
      tick_count_r   <= 8'd0;
      data_level_r   <= 1'b0;
      drive_enable_r <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r         <= mode_nxt;
        select_on_r    <= select_on_nxt;
        select_index_r <= select_index_nxt;
        shift_reg_r    <= shift_reg_nxt;
        receive_acc_r  <= receive_acc_nxt;
        bits_left_r    <= bits_left_nxt;
        second_half_r  <= second_half_nxt;
        tick_count_r   <= tick_count_nxt;
        data_level_r   <= data_level_nxt;
        drive_enable_r <= drive_enable_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_three_wire_spi_master.sv */
module tb_three_wire_spi_master;
  timeunit 1ns;
  timeprecision 1ps;

  import twsm_pkg::*;

  localparam int DEV_COUNT = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP = 200;
  // Indexes past the register list; writes there must change nothing.
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    op_t        op;
    logic [7:0] tx;
    logic       last;
    logic [2:0] dev;
    logic       dio;
  } tick_item_t;

  typedef struct packed {
    logic       sclk;
    logic       dio_out;
    logic       dio_drive;
    logic       cs_active;
    logic [2:0] cs_device;
    logic       busy;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rejected;
  } pin_word_t;

  typedef enum logic [1:0] {
    READY_ALWAYS = 2'd0,
    READY_RANDOM = 2'd1,
    READY_TOGGLE = 2'd2,
    READY_RUNS   = 2'd3
  } ready_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_TICK;
  logic        in_tlast = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic        out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;

  // Register copies held by the predictor.
  logic       pol_high, smp_trail, lsb_order;
  logic [3:0] tail_bits;
  logic [7:0] half_ext, gap_len;

  // Engine state held by the predictor.
  mode_t      eng_mode;
  logic       sel_on, in_second, clk_lvl, dat_lvl, drv_en;
  logic [2:0] sel_idx;
  logic [7:0] shifter, rx_acc, tcount;
  logic [3:0] bits_rem;
  logic [7:0] rx_now;
  logic       rx_seen;

  tick_item_t ticks_to_send[$];
  pin_word_t  pin_words_due[$];
  tick_item_t on_bus;
  pin_word_t  seen, want;
  int ticks_queued = 0;
  int ticks_taken = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  ready_style_t ready_style = READY_ALWAYS;
  int style_left = 0;
  int run_left = 0;

  three_wire_spi_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void start_bit(input logic dio);
    in_second = 1'b0;
    tcount = half_ext;
    if (eng_mode == MODE_SEND) begin
      dat_lvl = lsb_order ? shifter[0] : shifter[7];
    end else if (!smp_trail && dio) begin
      rx_acc = rx_acc | shifter;
    end
  endfunction

  function automatic void close_byte();
    if (eng_mode == MODE_RECV) begin
      rx_now = rx_acc;
      rx_seen = 1'b1;
    end
    in_second = 1'b0;
    tcount = gap_len;
    eng_mode = (gap_len != 8'd0) ? MODE_GAP : MODE_IDLE;
  endfunction

  // One tick of the bit timer: updates the engine state and returns the pin word.
  function automatic pin_word_t advance_engine(input tick_item_t it);
    pin_word_t r;
    logic [3:0] nb;
    logic rej;
    rej = 1'b0;
    rx_now = 8'h00;
    rx_seen = 1'b0;
    if (eng_mode == MODE_IDLE) begin
      if (it.op == OP_SEND || it.op == OP_RECV) begin
        nb = it.last ? ((tail_bits > FULL_BYTE_BITS) ? FULL_BYTE_BITS : tail_bits)
                     : FULL_BYTE_BITS;
        sel_on = 1'b1;
        sel_idx = (int'(it.dev) >= DEV_COUNT) ? 3'(DEV_COUNT - 1) : it.dev;
        bits_rem = nb;
        rx_acc = 8'h00;
        if (it.op == OP_SEND) begin
          eng_mode = MODE_SEND;
          drv_en = 1'b1;
          shifter = it.tx;
        end else begin
          eng_mode = MODE_RECV;
          drv_en = 1'b0;
          shifter = lsb_order ? RX_MASK_LSB : RX_MASK_MSB;
        end
        if (nb == 4'd0) close_byte();
        else start_bit(it.dio);
      end else if (it.op == OP_END) begin
        sel_on = 1'b0;
        drv_en = 1'b1;
      end
    end else begin
      if (it.op != OP_TICK) rej = 1'b1;
      if (eng_mode == MODE_GAP) begin
        if (tcount > 8'd0) tcount = tcount - 8'd1;
        if (tcount == 8'd0) eng_mode = MODE_IDLE;
      end else if (tcount > 8'd0) begin
        tcount = tcount - 8'd1;
      end else if (!in_second) begin
        in_second = 1'b1;
        tcount = half_ext;
        if (eng_mode == MODE_RECV && smp_trail && it.dio) rx_acc = rx_acc | shifter;
      end else begin
        if (bits_rem > 4'd0) bits_rem = bits_rem - 4'd1;
        if (eng_mode == MODE_SEND) shifter = lsb_order ? shifter >> 1 : shifter << 1;
        else shifter = lsb_order ? shifter << 1 : shifter >> 1;
        if (bits_rem > 4'd0) start_bit(it.dio);
        else close_byte();
      end
    end
    clk_lvl = ((eng_mode == MODE_SEND || eng_mode == MODE_RECV) && !in_second) ?
              ~pol_high : pol_high;
    r.sclk = clk_lvl;
    r.dio_out = dat_lvl;
    r.dio_drive = drv_en;
    r.cs_active = sel_on;
    r.cs_device = sel_idx;
    r.busy = (eng_mode != MODE_IDLE);
    r.rx_byte = rx_now;
    r.rx_valid = rx_seen;
    r.rejected = rej;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, exp_val);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pin_words_due.push_back(advance_engine(on_bus));
        ticks_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (ticks_to_send.size() != 0) begin
          on_bus = ticks_to_send.pop_front();
          in_tdata <= {4'b0000, on_bus.dio, on_bus.dev, on_bus.tx};
          in_tuser <= on_bus.op;
          in_tlast <= on_bus.last;
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each word and stalls in one of several styles.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.sclk = out_tdata[0];
      seen.dio_out = out_tdata[1];
      seen.dio_drive = out_tdata[2];
      seen.cs_active = out_tdata[3];
      seen.cs_device = out_tdata[6:4];
      seen.busy = out_tdata[7];
      seen.rx_byte = out_tdata[15:8];
      seen.rejected = out_tdata[16];
      seen.rx_valid = out_tuser;
      if (pin_words_due.size() == 0) begin
        report_mismatch("result word with no tick outstanding", out_tdata[7:0], 8'h00);
      end else begin
        want = pin_words_due.pop_front();
        if (seen.sclk !== want.sclk) report_mismatch("sclk", seen.sclk, want.sclk);
        if (seen.dio_out !== want.dio_out)
          report_mismatch("dio_out", seen.dio_out, want.dio_out);
        if (seen.dio_drive !== want.dio_drive)
          report_mismatch("dio_drive", seen.dio_drive, want.dio_drive);
        if (seen.cs_active !== want.cs_active)
          report_mismatch("cs_active", seen.cs_active, want.cs_active);
        if (seen.cs_device !== want.cs_device)
          report_mismatch("cs_device", seen.cs_device, want.cs_device);
        if (seen.busy !== want.busy) report_mismatch("busy", seen.busy, want.busy);
        if (seen.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", seen.rx_byte, want.rx_byte);
        if (seen.rx_valid !== want.rx_valid)
          report_mismatch("rx_valid", seen.rx_valid, want.rx_valid);
        if (seen.rejected !== want.rejected)
          report_mismatch("cmd_rejected", seen.rejected, want.rejected);
      end
    end
    if (style_left == 0) begin
      ready_style <= ready_style_t'($urandom_range(0, 3));
      style_left <= $urandom_range(32, 200);
    end else begin
      style_left <= style_left - 1;
    end
    case (ready_style)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_RANDOM: out_tready <= ($urandom_range(0, 2) != 0);
      READY_TOGGLE: out_tready <= ~out_tready;
      READY_RUNS: begin
        if (run_left == 0) begin
          out_tready <= ~out_tready;
          run_left <= $urandom_range(1, 12);
        end else begin
          run_left <= run_left - 1;
        end
      end
      default: out_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_item(input tick_item_t t);
    ticks_to_send.push_back(t);
    ticks_queued++;
  endtask

  task automatic push_fields(input op_t op, input logic [7:0] tx, input logic last,
                             input logic [2:0] dev, input logic dio);
    tick_item_t t;
    t.op = op;
    t.tx = tx;
    t.last = last;
    t.dev = dev;
    t.dio = dio;
    push_item(t);
  endtask

  function automatic tick_item_t random_item(input op_t op);
    tick_item_t t;
    t.op = op;
    t.tx = 8'($urandom);
    t.last = 1'($urandom);
    t.dev = 3'($urandom);
    t.dio = 1'($urandom);
    return t;
  endfunction

  // Caller holds cfg_valid high across the whole batch of writes.
  task automatic load_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CLOCK_IDLE_HIGH: pol_high = val[0];
      CFG_SAMPLE_TRAILING: smp_trail = val[0];
      CFG_LSB_FIRST:       lsb_order = val[0];
      CFG_LAST_BITS:       tail_bits = val[3:0];
      CFG_BIT_DELAY:       half_ext = val;
      CFG_BYTE_DELAY:      gap_len = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic cih, input logic st, input logic lsb,
                            input logic [3:0] lb, input logic [7:0] bd,
                            input logic [7:0] byd);
    cfg_valid <= 1'b1;
    load_reg(CFG_CLOCK_IDLE_HIGH, {7'($urandom), cih});
    load_reg(CFG_SAMPLE_TRAILING, {7'($urandom), st});
    load_reg(CFG_LSB_FIRST, {7'($urandom), lsb});
    load_reg(CFG_LAST_BITS, {4'($urandom), lb});
    load_reg(CFG_BIT_DELAY, bd);
    load_reg(CFG_BYTE_DELAY, byd);
    if ($urandom_range(0, 1) == 1)
      load_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B, 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Waits for every word to come back, then ticks the engine until it is idle.
  task automatic drain_to_idle();
    do begin
      while (ticks_taken != ticks_queued || pin_words_due.size() != 0) @(posedge clk);
      if (eng_mode != MODE_IDLE)
        for (int k = 0; k < 16; k++) push_item(random_item(OP_TICK));
    end while (eng_mode != MODE_IDLE || ticks_taken != ticks_queued);
    repeat (3) @(posedge clk);
  endtask

  // A select, one to four bytes (send phase, then receive phase) and an end.
  // Filler counts aim at the tick where the engine goes idle, give or take.
  task automatic gen_transfer(input int target);
    tick_item_t t;
    logic [2:0] dev;
    logic [3:0] nb;
    int nbytes, nsend, span, fill;
    dev = 3'($urandom);
    nbytes = $urandom_range(1, 4);
    nsend = $urandom_range(0, nbytes);
    for (int b = 0; b < nbytes && ticks_queued < target; b++) begin
      t = random_item((b < nsend) ? OP_SEND : OP_RECV);
      if ($urandom_range(0, 9) != 0) t.dev = dev;
      t.last = (b == nsend - 1) || (b == nbytes - 1);
      push_item(t);
      nb = t.last ? ((tail_bits > FULL_BYTE_BITS) ? FULL_BYTE_BITS : tail_bits)
                  : FULL_BYTE_BITS;
      span = 2 * int'(nb) * (int'(half_ext) + 1) + int'(gap_len);
      if ($urandom_range(0, 7) == 0) fill = $urandom_range(0, span);
      else fill = span + int'($urandom_range(0, 4)) - 2;
      for (int k = 0; k < fill && ticks_queued < target; k++)
        push_item(random_item(($urandom_range(0, 6) == 0) ?
                              op_t'($urandom_range(1, 3)) : OP_TICK));
    end
    push_item(random_item(OP_END));
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 4)) push_item(random_item(op_t'($urandom_range(0, 3))));
  endtask

  task automatic run_phase(input logic cih, input logic st, input logic lsb,
                           input logic [3:0] lb, input logic [7:0] bd,
                           input logic [7:0] byd, input int count);
    int target;
    set_config(cih, st, lsb, lb, bd, byd);
    target = ticks_queued + count;
    while (ticks_queued < target) gen_transfer(target);
    drain_to_idle();
  endtask

  initial begin
    pol_high = 1'b0;
    smp_trail = 1'b0;
    lsb_order = 1'b0;
    tail_bits = FULL_BYTE_BITS;
    half_ext = 8'd0;
    gap_len = 8'd0;
    eng_mode = MODE_IDLE;
    sel_on = 1'b0;
    sel_idx = 3'd0;
    shifter = 8'h00;
    rx_acc = 8'h00;
    bits_rem = 4'd0;
    in_second = 1'b0;
    tcount = 8'd0;
    clk_lvl = 1'b0;
    dat_lvl = 1'b0;
    drv_en = 1'b1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two-bit last bytes: end while idle, commands during a byte and on its
    // completion tick, then a full-length read.
    set_config(1'b0, 1'b0, 1'b0, 4'd2, 8'd0, 8'd0);
    push_fields(OP_END, 8'h00, 1'b0, 3'd5, 1'b0);
    push_fields(OP_TICK, 8'hFF, 1'b1, 3'd7, 1'b1);
    push_fields(OP_SEND, 8'hFF, 1'b1, 3'd7, 1'b1);
    push_fields(OP_TICK, 8'h00, 1'b0, 3'd0, 1'b0);
    push_fields(OP_SEND, 8'h3C, 1'b0, 3'd2, 1'b1);
    push_fields(OP_RECV, 8'hC3, 1'b1, 3'd1, 1'b0);
    push_fields(OP_END, 8'h00, 1'b0, 3'd0, 1'b0);
    push_fields(OP_RECV, 8'h00, 1'b0, 3'd0, 1'b1);
    for (int k = 0; k < 6; k++) push_fields(OP_TICK, 8'h00, 1'b0, 3'd0, k[0]);
    drain_to_idle();

    // A zero bit count makes the accepting tick the completion tick.
    set_config(1'b1, 1'b1, 1'b1, 4'd0, 8'd1, 8'd1);
    push_fields(OP_SEND, 8'h00, 1'b1, 3'd3, 1'b0);
    push_fields(OP_TICK, 8'h00, 1'b0, 3'd3, 1'b1);
    push_fields(OP_RECV, 8'h00, 1'b1, 3'd3, 1'b1);
    push_fields(OP_TICK, 8'h00, 1'b0, 3'd3, 1'b0);
    push_fields(OP_END, 8'h00, 1'b0, 3'd3, 1'b0);
    push_fields(OP_SEND, 8'h5A, 1'b0, 3'd4, 1'b1);
    drain_to_idle();

    // Bit counts above eight behave as eight.
    set_config(1'b0, 1'b1, 1'b0, 4'd15, 8'd0, 8'd0);
    push_fields(OP_RECV, 8'hA5, 1'b1, 3'd6, 1'b1);
    push_fields(OP_TICK, 8'h00, 1'b0, 3'd6, 1'b1);
    drain_to_idle();

    run_phase(1'b0, 1'b0, 1'b0, 4'd8, 8'd0, 8'd0, 300);
    run_phase(1'b1, 1'b1, 1'b1, 4'd8, 8'd0, 8'd0, 300);
    run_phase(1'b0, 1'b1, 1'b0, 4'd3, 8'd1, 8'd2, 300);
    run_phase(1'b1, 1'b0, 1'b1, 4'd1, 8'd2, 8'd0, 250);
    repeat (3)
      run_phase(1'($urandom), 1'($urandom), 1'($urandom), 4'($urandom_range(0, 15)),
                8'($urandom_range(0, 3)), 8'($urandom_range(0, 6)), 150);
    run_phase(1'b1, 1'b0, 1'b0, 4'd8, 8'd0, 8'd255, 60);
    run_phase(1'b0, 1'b1, 1'b1, 4'd1, 8'd9, 8'd3, 80);

    drain_to_idle();
    if (pin_words_due.size() != 0)
      report_mismatch("result words never returned", 8'(pin_words_due.size()), 8'h00);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/twsm_pkg.sv
hw/rtl/three_wire_spi_master.sv
tb/sv/tb_three_wire_spi_master.sv
